// ===== src/pfra_pkg.sv =====
// ----------------------------------------------------------------------------
// pfra_pkg
// Shared types, constants and helpers of the page frame refcount allocator.
// ----------------------------------------------------------------------------
package pfra_pkg;

	localparam int NUM_PAGES = 4096;
	localparam int ADDR_W    = $clog2(NUM_PAGES);
	localparam int CNT_W     = ADDR_W + 1;
	localparam int PAGE_W    = 20;
	localparam int CFG_W     = 21;
	localparam int IDX_W     = 2;
	localparam int REF_W     = 8;
	localparam int STAT_W    = 2;
	localparam int CMD_W     = 3;

	localparam logic [IDX_W-1:0] REG_BUFFER_START = 2'd0;
	localparam logic [IDX_W-1:0] REG_APP_START    = 2'd1;
	localparam logic [IDX_W-1:0] REG_END          = 2'd2;

	localparam logic [CFG_W-1:0] BUFFER_START_RST = 21'd512;
	localparam logic [CFG_W-1:0] APP_START_RST    = 21'd1024;
	localparam logic [CFG_W-1:0] END_RST          = 21'd4096;

	localparam logic [CMD_W-1:0] CMD_INIT       = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ALLOC_BUF  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_ALLOC_APP  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_FREE       = 3'd3;
	localparam logic [CMD_W-1:0] CMD_ADD_REF    = 3'd4;

	localparam logic [REF_W-1:0] CNT_FREE     = 8'd0;
	localparam logic [REF_W-1:0] CNT_ONE      = 8'd1;
	localparam logic [REF_W-1:0] CNT_MAX      = 8'd254;
	localparam logic [REF_W-1:0] CNT_RESERVED = 8'd255;

	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOFREE   = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOPAGE   = 2'd2;
	localparam logic [STAT_W-1:0] ST_FREEFREE = 2'd3;

	localparam logic [1:0] CNT_HOLD = 2'd0;
	localparam logic [1:0] CNT_ZERO = 2'd1;
	localparam logic [1:0] CNT_LO   = 2'd2;
	localparam logic [1:0] CNT_INC  = 2'd3;

	localparam logic [1:0] RES_DIRECT = 2'd0;
	localparam logic [1:0] RES_FOUND  = 2'd1;
	localparam logic [1:0] RES_RMW    = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [PAGE_W-1:0] page;
	} req_t;

	typedef struct packed {
		logic [PAGE_W-1:0] result_page;
		logic [REF_W-1:0]  ref_count;
		logic [STAT_W-1:0] status;
	} rsp_t;

	typedef struct packed {
		logic       in_load;
		logic [1:0] cnt_op;
		logic       fill;
		logic       fill_init;
		logic       scan;
		logic       rd_page;
		logic       rmw;
		logic       res_load;
		logic [1:0] res_sel;
		logic       out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             range_ok;
		logic             cnt_last;
		logic             scan_hit;
		logic             scan_end;
		logic             out_free;
	} dp_stat_t;

	function automatic logic [CNT_W-1:0] clip(input logic [CFG_W-1:0] v);
		if (v > CFG_W'(NUM_PAGES)) begin
			return CNT_W'(NUM_PAGES);
		end
		return v[CNT_W-1:0];
	endfunction

endpackage

// ===== src/pfra_dp.sv =====
// ----------------------------------------------------------------------------
// pfra_dp
// Count table, zone registers, sweep counter, result and output registers.
// ----------------------------------------------------------------------------
module pfra_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pfra_pkg::IDX_W-1:0]      cfg_index,
	input  logic [pfra_pkg::CFG_W-1:0]      cfg_data,
	input  pfra_pkg::req_t                  req,
	output pfra_pkg::rsp_t                  rsp,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	input  pfra_pkg::dp_cmd_t               ctl,
	output pfra_pkg::dp_stat_t              stat
);

	logic [pfra_pkg::CFG_W-1:0]  buf_start_q;
	logic [pfra_pkg::CFG_W-1:0]  app_start_q;
	logic [pfra_pkg::CFG_W-1:0]  end_q;
	logic [pfra_pkg::CMD_W-1:0]  cmd_q;
	logic [pfra_pkg::PAGE_W-1:0] page_q;
	logic [pfra_pkg::CNT_W-1:0]  cnt_q;
	logic                        rd_valid_s1;
	logic [pfra_pkg::ADDR_W-1:0] rd_addr_s1;
	logic [pfra_pkg::REF_W-1:0]  rd_data_s1;
	pfra_pkg::rsp_t              res_q;
	pfra_pkg::rsp_t              out_q;
	logic                        out_valid_q;

	logic [pfra_pkg::REF_W-1:0]  mem [pfra_pkg::NUM_PAGES];

	logic [pfra_pkg::CNT_W-1:0]  lo;
	logic [pfra_pkg::CNT_W-1:0]  hi;
	logic [pfra_pkg::CNT_W-1:0]  init_lo;
	logic [pfra_pkg::CNT_W-1:0]  init_hi;
	logic                        issue;
	logic                        page_exists;
	logic                        in_app_zone;
	logic                        we;
	logic [pfra_pkg::ADDR_W-1:0] waddr;
	logic [pfra_pkg::REF_W-1:0]  wdata;
	logic                        re;
	logic [pfra_pkg::ADDR_W-1:0] raddr;
	logic                        rmw_we;
	logic [pfra_pkg::REF_W-1:0]  rmw_cnt;
	pfra_pkg::rsp_t              res_direct;
	pfra_pkg::rsp_t              res_rmw;
	pfra_pkg::rsp_t              res_found;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_start_q <= pfra_pkg::BUFFER_START_RST;
			app_start_q <= pfra_pkg::APP_START_RST;
			end_q       <= pfra_pkg::END_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pfra_pkg::REG_BUFFER_START: buf_start_q <= cfg_data;
				pfra_pkg::REG_APP_START:    app_start_q <= cfg_data;
				pfra_pkg::REG_END:          end_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.in_load) begin
			cmd_q  <= req.cmd;
			page_q <= req.page;
		end
	end

	always_comb begin
		if (cmd_q == pfra_pkg::CMD_ALLOC_BUF) begin
			lo = pfra_pkg::clip(buf_start_q);
			hi = pfra_pkg::clip(app_start_q);
		end else begin
			lo = pfra_pkg::clip(app_start_q);
			hi = pfra_pkg::clip(end_q);
		end
	end

	assign init_lo = pfra_pkg::clip(buf_start_q);
	assign init_hi = pfra_pkg::clip(end_q);

	assign issue = ctl.scan && (cnt_q < hi);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (ctl.cnt_op)
				pfra_pkg::CNT_ZERO: cnt_q <= '0;
				pfra_pkg::CNT_LO:   cnt_q <= lo;
				pfra_pkg::CNT_INC: begin
					if (!ctl.scan || issue) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_s1 <= cnt_q[pfra_pkg::ADDR_W-1:0];
	end

	assign page_exists = {1'b0, page_q} < pfra_pkg::CFG_W'(pfra_pkg::NUM_PAGES);
	assign in_app_zone = ({1'b0, page_q} >= app_start_q) && ({1'b0, page_q} < end_q);

	always_comb begin
		rmw_cnt = rd_data_s1;
		rmw_we  = 1'b0;
		res_rmw = '{result_page: page_q, ref_count: rd_data_s1, status: pfra_pkg::ST_OK};
		if (rd_data_s1 == pfra_pkg::CNT_RESERVED) begin
			res_rmw.status = pfra_pkg::ST_NOPAGE;
		end else if (cmd_q == pfra_pkg::CMD_FREE) begin
			if (rd_data_s1 == pfra_pkg::CNT_FREE) begin
				res_rmw.status = pfra_pkg::ST_FREEFREE;
			end else begin
				rmw_cnt = rd_data_s1 - 1'b1;
				rmw_we  = 1'b1;
			end
		end else begin
			if (rd_data_s1 < pfra_pkg::CNT_MAX) begin
				rmw_cnt = rd_data_s1 + 1'b1;
			end
			rmw_we = 1'b1;
		end
		res_rmw.ref_count = rmw_cnt;
	end

	always_comb begin
		res_direct = '{result_page: page_q, ref_count: pfra_pkg::CNT_FREE,
			status: pfra_pkg::ST_OK};
		case (cmd_q)
			pfra_pkg::CMD_INIT: res_direct.result_page = '0;
			pfra_pkg::CMD_ALLOC_BUF, pfra_pkg::CMD_ALLOC_APP: begin
				res_direct.result_page = '0;
				res_direct.status      = pfra_pkg::ST_NOFREE;
			end
			pfra_pkg::CMD_FREE, pfra_pkg::CMD_ADD_REF: res_direct.status = pfra_pkg::ST_NOPAGE;
			default: ;
		endcase
	end

	assign res_found = '{result_page: pfra_pkg::PAGE_W'(rd_addr_s1),
		ref_count: pfra_pkg::CNT_ONE, status: pfra_pkg::ST_OK};

	always_comb begin
		we    = 1'b0;
		waddr = cnt_q[pfra_pkg::ADDR_W-1:0];
		wdata = pfra_pkg::CNT_FREE;
		if (ctl.fill) begin
			we = 1'b1;
			if (ctl.fill_init && !((cnt_q >= init_lo) && (cnt_q < init_hi))) begin
				wdata = pfra_pkg::CNT_RESERVED;
			end
		end else if (ctl.scan && stat.scan_hit) begin
			we    = 1'b1;
			waddr = rd_addr_s1;
			wdata = pfra_pkg::CNT_ONE;
		end else if (ctl.rmw) begin
			we    = rmw_we;
			waddr = page_q[pfra_pkg::ADDR_W-1:0];
			wdata = rmw_cnt;
		end
	end

	assign re    = issue || ctl.rd_page;
	assign raddr = ctl.rd_page ? page_q[pfra_pkg::ADDR_W-1:0] : cnt_q[pfra_pkg::ADDR_W-1:0];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_data_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.res_load) begin
			case (ctl.res_sel)
				pfra_pkg::RES_FOUND: res_q <= res_found;
				pfra_pkg::RES_RMW:   res_q <= res_rmw;
				default:             res_q <= res_direct;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_q <= res_q;
		end
	end

	assign rsp       = out_q;
	assign rsp_valid = out_valid_q;

	assign stat.cmd      = cmd_q;
	assign stat.range_ok = (cmd_q == pfra_pkg::CMD_FREE) ? (page_exists && in_app_zone)
		: page_exists;
	assign stat.cnt_last = cnt_q == pfra_pkg::CNT_W'(pfra_pkg::NUM_PAGES - 1);
	assign stat.scan_hit = rd_valid_s1 && (rd_data_s1 == pfra_pkg::CNT_FREE);
	assign stat.scan_end = !rd_valid_s1 && !(cnt_q < hi);
	assign stat.out_free = !out_valid_q || !rsp_stall;

endmodule

// ===== src/pfra_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfra_ctrl
// Sequencer: clearing pass, decode, init sweep, zone scan, read-modify-write.
// ----------------------------------------------------------------------------
module pfra_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	output pfra_pkg::dp_cmd_t     ctl,
	input  pfra_pkg::dp_stat_t    stat
);

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_DECODE = 3'd2;
	localparam logic [2:0] S_INIT   = 3'd3;
	localparam logic [2:0] S_SCAN   = 3'd4;
	localparam logic [2:0] S_MODIFY = 3'd5;
	localparam logic [2:0] S_PUSH   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign req_stall = state_q != S_IDLE;

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			S_CLEAR: begin
				ctl.fill   = 1'b1;
				ctl.cnt_op = pfra_pkg::CNT_INC;
				if (stat.cnt_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					ctl.in_load = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				case (stat.cmd)
					pfra_pkg::CMD_INIT: begin
						ctl.cnt_op = pfra_pkg::CNT_ZERO;
						state_d    = S_INIT;
					end
					pfra_pkg::CMD_ALLOC_BUF, pfra_pkg::CMD_ALLOC_APP: begin
						ctl.cnt_op = pfra_pkg::CNT_LO;
						state_d    = S_SCAN;
					end
					pfra_pkg::CMD_FREE, pfra_pkg::CMD_ADD_REF: begin
						if (stat.range_ok) begin
							ctl.rd_page = 1'b1;
							state_d     = S_MODIFY;
						end else begin
							ctl.res_load = 1'b1;
							ctl.res_sel  = pfra_pkg::RES_DIRECT;
							state_d      = S_PUSH;
						end
					end
					default: begin
						ctl.res_load = 1'b1;
						ctl.res_sel  = pfra_pkg::RES_DIRECT;
						state_d      = S_PUSH;
					end
				endcase
			end
			S_INIT: begin
				ctl.fill      = 1'b1;
				ctl.fill_init = 1'b1;
				ctl.cnt_op    = pfra_pkg::CNT_INC;
				if (stat.cnt_last) begin
					ctl.res_load = 1'b1;
					ctl.res_sel  = pfra_pkg::RES_DIRECT;
					state_d      = S_PUSH;
				end
			end
			S_SCAN: begin
				ctl.scan   = 1'b1;
				ctl.cnt_op = pfra_pkg::CNT_INC;
				if (stat.scan_hit) begin
					ctl.res_load = 1'b1;
					ctl.res_sel  = pfra_pkg::RES_FOUND;
					state_d      = S_PUSH;
				end else if (stat.scan_end) begin
					ctl.res_load = 1'b1;
					ctl.res_sel  = pfra_pkg::RES_DIRECT;
					state_d      = S_PUSH;
				end
			end
			S_MODIFY: begin
				ctl.rmw      = 1'b1;
				ctl.res_load = 1'b1;
				ctl.res_sel  = pfra_pkg::RES_RMW;
				state_d      = S_PUSH;
			end
			S_PUSH: begin
				if (stat.out_free) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== src/page_frame_refcount_allocator.sv =====
// ----------------------------------------------------------------------------
// page_frame_refcount_allocator
// Physical page allocator keeping one 8-bit reference count per page frame.
// ----------------------------------------------------------------------------
// After reset the block sweeps the count table to zero, one entry a cycle,
// before it takes the first word; configuration writes are taken during
// that pass. Reset does not lay out the zones: software issues an init
// command before relying on the reserved marks. The count table is a single
// memory with one write and one registered read port; init, allocation,
// free and add-reference reach it through those ports, unused codes do not.
// Init rewrites every entry, an allocation reads the zone entry by entry
// until it finds a free page or passes the zone end, and free and
// add-reference on a page in range read its count and update it. A stalled
// output holds the sequencer in its push state while the previous result
// waits. One word is worked on at a time; a finished result waits in the
// output register while the next word is taken.
module page_frame_refcount_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pfra_pkg::IDX_W-1:0]    cfg_index,
	input  logic [pfra_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  pfra_pkg::req_t                req,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output pfra_pkg::rsp_t                rsp
);

	pfra_pkg::dp_cmd_t  ctl;
	pfra_pkg::dp_stat_t stat;

	pfra_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.ctl       (ctl),
		.stat      (stat)
	);

	pfra_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.ctl       (ctl),
		.stat      (stat)
	);

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Regression bench for the page frame refcount allocator. A directed table
// covers after-reset behavior, zone edges, error codes and the spare command
// codes, followed by a short add-reference burst on one page. Random words
// then run under several zone layouts and idle patterns. Every response word
// is checked against its directed row or an in-bench model of the count table.
// ----------------------------------------------------------------------------
module tb;

	localparam logic [pfra_pkg::CMD_W-1:0] CMD_SPARE5 = 3'd5;
	localparam logic [pfra_pkg::CMD_W-1:0] CMD_SPARE6 = 3'd6;
	localparam logic [pfra_pkg::CMD_W-1:0] CMD_SPARE7 = 3'd7;
	localparam int                         HOT_PAGE   = 1500;
	localparam int                         CYCLE_CAP  = 8000000;

	typedef struct packed {
		pfra_pkg::req_t w;
		logic           has_rsp;
		pfra_pkg::rsp_t r;
	} table_row_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [pfra_pkg::IDX_W-1:0]     cfg_index;
	logic [pfra_pkg::CFG_W-1:0]     cfg_data;
	logic                           req_valid;
	logic                           req_stall;
	pfra_pkg::req_t                 req;
	logic                           rsp_valid;
	logic                           rsp_stall;
	pfra_pkg::rsp_t                 rsp;

	logic                           word_has_rsp;
	pfra_pkg::rsp_t                 word_rsp;
	table_row_t                     directed_rows [0:24];

	bit   [pfra_pkg::REF_W-1:0]     page_count [pfra_pkg::NUM_PAGES];
	int                             buf_start;
	int                             app_start;
	int                             end_page;
	int                             held_pages [$];
	pfra_pkg::rsp_t                 pending_rsp [$];
	int                             errors;
	int                             cycles;
	int                             send_idle_pct;
	int                             recv_stall_pct;

	page_frame_refcount_allocator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("page_frame_refcount_allocator regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	function automatic int table_bound(input int v);
		return (v > pfra_pkg::NUM_PAGES) ? pfra_pkg::NUM_PAGES : v;
	endfunction

	function automatic pfra_pkg::rsp_t predict_count(input pfra_pkg::req_t w);
		pfra_pkg::rsp_t             r;
		int                         lo;
		int                         hi;
		int                         pg;
		logic [pfra_pkg::REF_W-1:0] c;
		pg = int'(w.page);
		r  = '{w.page, pfra_pkg::CNT_FREE, pfra_pkg::ST_OK};
		case (w.cmd)
			pfra_pkg::CMD_INIT: begin
				lo = table_bound(buf_start);
				hi = table_bound(end_page);
				for (int i = 0; i < pfra_pkg::NUM_PAGES; i++) begin
					page_count[i] = (i >= lo && i < hi) ? pfra_pkg::CNT_FREE
						: pfra_pkg::CNT_RESERVED;
				end
				held_pages.delete();
				r = '{'0, pfra_pkg::CNT_FREE, pfra_pkg::ST_OK};
			end
			pfra_pkg::CMD_ALLOC_BUF, pfra_pkg::CMD_ALLOC_APP: begin
				lo = table_bound((w.cmd == pfra_pkg::CMD_ALLOC_BUF) ? buf_start : app_start);
				hi = table_bound((w.cmd == pfra_pkg::CMD_ALLOC_BUF) ? app_start : end_page);
				r  = '{'0, pfra_pkg::CNT_FREE, pfra_pkg::ST_NOFREE};
				for (int i = lo; i < hi; i++) begin
					if (page_count[i] == pfra_pkg::CNT_FREE) begin
						page_count[i] = pfra_pkg::CNT_ONE;
						r = '{pfra_pkg::PAGE_W'(i), pfra_pkg::CNT_ONE, pfra_pkg::ST_OK};
						held_pages.push_back(i);
						break;
					end
				end
			end
			pfra_pkg::CMD_FREE: begin
				if (pg < app_start || pg >= end_page || pg >= pfra_pkg::NUM_PAGES) begin
					r.status = pfra_pkg::ST_NOPAGE;
				end else begin
					c = page_count[pg];
					if (c == pfra_pkg::CNT_RESERVED) begin
						r.ref_count = pfra_pkg::CNT_RESERVED;
						r.status    = pfra_pkg::ST_NOPAGE;
					end else if (c == pfra_pkg::CNT_FREE) begin
						r.status = pfra_pkg::ST_FREEFREE;
					end else begin
						page_count[pg] = c - 1'b1;
						r.ref_count    = c - 1'b1;
					end
				end
			end
			pfra_pkg::CMD_ADD_REF: begin
				if (pg >= pfra_pkg::NUM_PAGES) begin
					r.status = pfra_pkg::ST_NOPAGE;
				end else begin
					c = page_count[pg];
					if (c == pfra_pkg::CNT_RESERVED) begin
						r.ref_count = pfra_pkg::CNT_RESERVED;
						r.status    = pfra_pkg::ST_NOPAGE;
					end else begin
						if (c < pfra_pkg::CNT_MAX) begin
							c = c + 1'b1;
						end
						page_count[pg] = c;
						r.ref_count    = c;
					end
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d want %0d (cycle %0d)", what, got, want, cycles);
		errors++;
	endtask

	always @(posedge clk) begin : scoreboard
		pfra_pkg::rsp_t want;
		if (req_valid && !req_stall) begin
			want = predict_count(req);
			pending_rsp.push_back(word_has_rsp ? word_rsp : want);
		end
		if (rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch("unexpected word, page", rsp.result_page, -1);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.result_page !== want.result_page) begin
					report_mismatch("result_page", rsp.result_page, want.result_page);
				end
				if (rsp.ref_count !== want.ref_count) begin
					report_mismatch("ref_count", rsp.ref_count, want.ref_count);
				end
				if (rsp.status !== want.status) begin
					report_mismatch("status", rsp.status, want.status);
				end
			end
		end
	end

	task automatic put_word(input pfra_pkg::req_t w, input logic has_rsp,
			input pfra_pkg::rsp_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req          <= w;
		req_valid    <= 1'b1;
		word_has_rsp <= has_rsp;
		word_rsp     <= r;
		@(posedge clk);
		while (req_stall) begin
			@(posedge clk);
		end
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (pending_rsp.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [pfra_pkg::IDX_W-1:0] idx, input int v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= pfra_pkg::CFG_W'(v);
		@(posedge clk);
		case (idx)
			pfra_pkg::REG_BUFFER_START: buf_start = v;
			pfra_pkg::REG_APP_START:    app_start = v;
			pfra_pkg::REG_END:          end_page  = v;
			default: begin
			end
		endcase
	endtask

	function automatic int pick_page();
		int roll;
		roll = $urandom_range(99);
		if (roll < 40 && held_pages.size() != 0) begin
			return held_pages[$urandom_range(0, held_pages.size() - 1)];
		end else if (roll < 60) begin
			return $urandom_range(0, 63);
		end else if (roll < 75) begin
			return $urandom_range(pfra_pkg::NUM_PAGES - 16, pfra_pkg::NUM_PAGES + 4);
		end
		return $urandom_range(0, 20'hFFFFF);
	endfunction

	function automatic pfra_pkg::req_t random_word();
		pfra_pkg::req_t w;
		int             roll;
		roll = $urandom_range(99);
		w.page = pfra_pkg::PAGE_W'($urandom_range(0, 20'hFFFFF));
		if (roll < 25) begin
			w.cmd = pfra_pkg::CMD_ALLOC_BUF;
		end else if (roll < 45) begin
			w.cmd = pfra_pkg::CMD_ALLOC_APP;
		end else if (roll < 65) begin
			w.cmd  = pfra_pkg::CMD_FREE;
			w.page = pfra_pkg::PAGE_W'(pick_page());
		end else if (roll < 88) begin
			w.cmd  = pfra_pkg::CMD_ADD_REF;
			w.page = pfra_pkg::PAGE_W'(pick_page());
		end else if (roll < 92) begin
			w.cmd = pfra_pkg::CMD_INIT;
		end else begin
			w.cmd = pfra_pkg::CMD_W'($urandom_range(CMD_SPARE5, CMD_SPARE7));
		end
		return w;
	endfunction

	task automatic run_random(input int n);
		repeat (n) begin
			if ($urandom_range(99) < 4) begin
				drain();
			end
			put_word(random_word(), 1'b0, '0);
		end
	endtask

	task automatic run_phase(input int send_pct, input int stall_pct, input int b,
			input int a, input int e, input int n);
		drain();
		send_idle_pct  = send_pct;
		recv_stall_pct = stall_pct;
		write_reg(pfra_pkg::REG_BUFFER_START, b);
		write_reg(pfra_pkg::REG_APP_START, a);
		write_reg(pfra_pkg::REG_END, e);
		cfg_we <= 1'b0;
		put_word('{pfra_pkg::CMD_INIT, '0}, 1'b0, '0);
		run_random(n);
	endtask

	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		req_valid      = 1'b0;
		req            = '0;
		word_has_rsp   = 1'b0;
		word_rsp       = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		buf_start      = int'(pfra_pkg::BUFFER_START_RST);
		app_start      = int'(pfra_pkg::APP_START_RST);
		end_page       = int'(pfra_pkg::END_RST);

		directed_rows = '{
			'{'{pfra_pkg::CMD_ALLOC_BUF, 20'd0},     1'b1,
				'{20'd512, pfra_pkg::CNT_ONE, pfra_pkg::ST_OK}},
			'{'{pfra_pkg::CMD_ADD_REF,   20'd7},     1'b0, '0},
			'{'{pfra_pkg::CMD_INIT,      20'hFFFFF}, 1'b1,
				'{20'd0, pfra_pkg::CNT_FREE, pfra_pkg::ST_OK}},
			'{'{pfra_pkg::CMD_ALLOC_BUF, 20'd0},     1'b1,
				'{20'd512, pfra_pkg::CNT_ONE, pfra_pkg::ST_OK}},
			'{'{pfra_pkg::CMD_ALLOC_APP, 20'd0},     1'b1,
				'{20'd1024, pfra_pkg::CNT_ONE, pfra_pkg::ST_OK}},
			'{'{pfra_pkg::CMD_ADD_REF,   20'd1024},  1'b1,
				'{20'd1024, 8'd2, pfra_pkg::ST_OK}},
			'{'{pfra_pkg::CMD_FREE,      20'd1024},  1'b1,
				'{20'd1024, pfra_pkg::CNT_ONE, pfra_pkg::ST_OK}},
			'{'{pfra_pkg::CMD_FREE,      20'd1024},  1'b1,
				'{20'd1024, pfra_pkg::CNT_FREE, pfra_pkg::ST_OK}},
			'{'{pfra_pkg::CMD_FREE,      20'd1024},  1'b1,
				'{20'd1024, pfra_pkg::CNT_FREE, pfra_pkg::ST_FREEFREE}},
			'{'{pfra_pkg::CMD_FREE,      20'd0},     1'b1,
				'{20'd0, pfra_pkg::CNT_FREE, pfra_pkg::ST_NOPAGE}},
			'{'{pfra_pkg::CMD_FREE,      20'd1023},  1'b1,
				'{20'd1023, pfra_pkg::CNT_FREE, pfra_pkg::ST_NOPAGE}},
			'{'{pfra_pkg::CMD_FREE,      20'd4096},  1'b1,
				'{20'd4096, pfra_pkg::CNT_FREE, pfra_pkg::ST_NOPAGE}},
			'{'{pfra_pkg::CMD_FREE,      20'hFFFFF}, 1'b1,
				'{20'hFFFFF, pfra_pkg::CNT_FREE, pfra_pkg::ST_NOPAGE}},
			'{'{pfra_pkg::CMD_ADD_REF,   20'd0},     1'b1,
				'{20'd0, pfra_pkg::CNT_RESERVED, pfra_pkg::ST_NOPAGE}},
			'{'{pfra_pkg::CMD_ADD_REF,   20'd511},   1'b1,
				'{20'd511, pfra_pkg::CNT_RESERVED, pfra_pkg::ST_NOPAGE}},
			'{'{pfra_pkg::CMD_ADD_REF,   20'd4095},  1'b1,
				'{20'd4095, pfra_pkg::CNT_ONE, pfra_pkg::ST_OK}},
			'{'{pfra_pkg::CMD_FREE,      20'd4095},  1'b1,
				'{20'd4095, pfra_pkg::CNT_FREE, pfra_pkg::ST_OK}},
			'{'{pfra_pkg::CMD_ADD_REF,   20'd4096},  1'b1,
				'{20'd4096, pfra_pkg::CNT_FREE, pfra_pkg::ST_NOPAGE}},
			'{'{pfra_pkg::CMD_ADD_REF,   20'hFFFFF}, 1'b1,
				'{20'hFFFFF, pfra_pkg::CNT_FREE, pfra_pkg::ST_NOPAGE}},
			'{'{CMD_SPARE5,              20'hFFFFF}, 1'b1,
				'{20'hFFFFF, pfra_pkg::CNT_FREE, pfra_pkg::ST_OK}},
			'{'{CMD_SPARE6,              20'h55555}, 1'b1,
				'{20'h55555, pfra_pkg::CNT_FREE, pfra_pkg::ST_OK}},
			'{'{CMD_SPARE7,              20'hAAAAA}, 1'b1,
				'{20'hAAAAA, pfra_pkg::CNT_FREE, pfra_pkg::ST_OK}},
			'{'{pfra_pkg::CMD_ALLOC_BUF, 20'h12345}, 1'b0, '0},
			'{'{pfra_pkg::CMD_FREE,      20'd512},   1'b1,
				'{20'd512, pfra_pkg::CNT_FREE, pfra_pkg::ST_NOPAGE}},
			'{'{pfra_pkg::CMD_ALLOC_APP, 20'd0},     1'b1,
				'{20'd1024, pfra_pkg::CNT_ONE, pfra_pkg::ST_OK}}
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[k]) begin
			put_word(directed_rows[k].w, directed_rows[k].has_rsp, directed_rows[k].r);
		end

		// stack references on one page, then drop one
		repeat (6) begin
			put_word('{pfra_pkg::CMD_ADD_REF, pfra_pkg::PAGE_W'(HOT_PAGE)}, 1'b0, '0);
		end
		put_word('{pfra_pkg::CMD_FREE, pfra_pkg::PAGE_W'(HOT_PAGE)}, 1'b0, '0);
		run_random(30);

		run_phase(71, 0, 0, 8, 24, 20);
		run_phase(0, 71, 24, 16, 40, 20);
		run_phase(25, 25, pfra_pkg::NUM_PAGES - 6, 1048576, 1048576, 15);
		run_phase(0, 0, 1048576, 0, 0, 15);

		drain();
		if (errors == 0) begin
			$display("page_frame_refcount_allocator regression: pass");
		end else begin
			$display("page_frame_refcount_allocator regression: fail");
		end
		$finish;
	end

endmodule
